>>> rtl/core/buq_pkg.sv
// Shared types, sizes and helpers for the buffered UART queue pair.
package buq_pkg;

	localparam int QUEUE_DEPTH = 256;
	localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int BYTE_W      = 8;
	localparam int CNT_W       = 32;
	localparam int ACTION_W    = 2;
	localparam int IN_DATA_W   = 8;
	// ok, data_out, tx_start, tx_busy, two counters, padded to whole bytes.
	localparam int OUT_USED_W  = 1 + BYTE_W + 1 + 1 + CNT_W + CNT_W;
	localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

	typedef logic [QIDX_W-1:0] qidx_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CNT_W-1:0]  count_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_RX_BYTE    = 2'd0,
		ACT_TX_TICK    = 2'd1,
		ACT_HOST_READ  = 2'd2,
		ACT_HOST_WRITE = 2'd3
	} action_t;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	function automatic qidx_t next_idx(qidx_t i);
		if (i == qidx_t'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return i + qidx_t'(1);
	endfunction

endpackage

>>> rtl/core/buffered_uart_queue_pair.sv
// A result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle; the popped byte comes from each queue RAM's read register.
// A new request is taken whenever the result register is empty or being drained.
// Reset clears queue indices, the busy flag and both counters; the queue RAM
// contents are left as they are and need no clearing pass.
module buffered_uart_queue_pair (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata: [7:0] data_in
	input  logic [buq_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// tuser: [1:0] action
	input  logic [buq_pkg::ACTION_W-1:0]        s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// tdata: [0] ok, [8:1] data_out, [9] tx_start, [10] tx_busy,
	// [42:11] rx_overflow_total, [74:43] tx_done_total, rest zero
	output logic [buq_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

	logic                 accept;
	buq_pkg::action_t     act;
	buq_pkg::queue_req_t  rx_req, tx_req;
	buq_pkg::queue_stat_t rx_stat, tx_stat;
	buq_pkg::byte_t       rx_rdata, tx_rdata;
	buq_pkg::byte_t       data_out;

	logic            ok_c, start_c, sel_rx_c, sel_tx_c, busy_c;
	logic            rx_push_c, rx_pop_c, tx_push_c, tx_pop_c;
	logic            ovf_inc_c, done_inc_c;

	logic            valid_s1, ok_s1, start_s1, sel_rx_s1, sel_tx_s1;
	logic            busy_q;
	buq_pkg::count_t ovf_q, done_q;

	assign s_axis_tready = !valid_s1 || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign act           = buq_pkg::action_t'(s_axis_tuser);

	always_comb begin
		ok_c       = 1'b0;
		start_c    = 1'b0;
		sel_rx_c   = 1'b0;
		sel_tx_c   = 1'b0;
		busy_c     = busy_q;
		rx_push_c  = 1'b0;
		rx_pop_c   = 1'b0;
		tx_push_c  = 1'b0;
		tx_pop_c   = 1'b0;
		ovf_inc_c  = 1'b0;
		done_inc_c = 1'b0;
		case (act)
			buq_pkg::ACT_RX_BYTE: begin
				if (rx_stat.full) begin
					ovf_inc_c = 1'b1;
				end else begin
					rx_push_c = 1'b1;
					ok_c      = 1'b1;
				end
			end
			buq_pkg::ACT_TX_TICK: begin
				// An empty queue on a tick means the transmitter went idle.
				if (tx_stat.empty) begin
					busy_c     = 1'b0;
					done_inc_c = 1'b1;
				end else begin
					tx_pop_c = 1'b1;
					sel_tx_c = 1'b1;
					ok_c     = 1'b1;
				end
			end
			buq_pkg::ACT_HOST_READ: begin
				if (!rx_stat.empty) begin
					rx_pop_c = 1'b1;
					sel_rx_c = 1'b1;
					ok_c     = 1'b1;
				end
			end
			buq_pkg::ACT_HOST_WRITE: begin
				if (!tx_stat.full) begin
					tx_push_c = 1'b1;
					ok_c      = 1'b1;
					if (!busy_q) begin
						start_c = 1'b1;
						busy_c  = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign rx_req.push = accept && rx_push_c;
	assign rx_req.pop  = accept && rx_pop_c;
	assign tx_req.push = accept && tx_push_c;
	assign tx_req.pop  = accept && tx_pop_c;

	buq_queue u_rx_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (rx_req),
		.wdata (s_axis_tdata),
		.stat  (rx_stat),
		.rdata (rx_rdata)
	);

	buq_queue u_tx_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (tx_req),
		.wdata (s_axis_tdata),
		.stat  (tx_stat),
		.rdata (tx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			busy_q   <= 1'b0;
			ovf_q    <= '0;
			done_q   <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (accept) begin
				busy_q <= busy_c;
				if (ovf_inc_c) begin
					ovf_q <= ovf_q + buq_pkg::count_t'(1);
				end
				if (done_inc_c) begin
					done_q <= done_q + buq_pkg::count_t'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1     <= ok_c;
			start_s1  <= start_c;
			sel_rx_s1 <= sel_rx_c;
			sel_tx_s1 <= sel_tx_c;
		end
	end

	// The RAM read registers hold while the result waits, since no pop is
	// issued until the result register drains.
	assign data_out = sel_rx_s1 ? rx_rdata : (sel_tx_s1 ? tx_rdata : '0);

	assign m_axis_tvalid = valid_s1;
	assign m_axis_tdata  = {
		(buq_pkg::OUT_DATA_W - buq_pkg::OUT_USED_W)'(0),
		done_q,
		ovf_q,
		busy_q,
		start_s1,
		data_out,
		ok_s1
	};

endmodule

>>> rtl/core/buq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module buq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/buq_queue.sv
// Circular byte queue: head and tail indices around one RAM, one slot kept empty.
module buq_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  buq_pkg::queue_req_t  req,
	input  buq_pkg::byte_t       wdata,
	output buq_pkg::queue_stat_t stat,
	output buq_pkg::byte_t       rdata
);

	buq_pkg::qidx_t head_q;
	buq_pkg::qidx_t tail_q;

	assign stat.empty = (head_q == tail_q);
	assign stat.full  = (buq_pkg::next_idx(head_q) == tail_q);

	// The caller only pushes when not full and pops when not empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (req.push) begin
				head_q <= buq_pkg::next_idx(head_q);
			end
			if (req.pop) begin
				tail_q <= buq_pkg::next_idx(tail_q);
			end
		end
	end

	buq_ram #(
		.WIDTH(buq_pkg::BYTE_W),
		.DEPTH(buq_pkg::QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (req.push),
		.waddr(head_q),
		.wdata(wdata),
		.re   (req.pop),
		.raddr(tail_q),
		.rdata(rdata)
	);

endmodule

>>> rtl/core/buq_checker.sv
// Port-level checks on the buffered UART queue pair, bound to the top level.
module buq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [buq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	// No result is offered while reset is held.
	assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// Every accepted request yields a result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted request produced no result");

	// A failed request returns a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
		else $error("nonzero data on failed request");

	// A start pulse always comes with ok and leaves the transmitter busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[10] && m_axis_tdata[0])
		else $error("start without busy or ok");

endmodule

bind buffered_uart_queue_pair buq_checker u_buq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

>>> sim/buffered_uart_queue_pair_tb.sv
// Self-checking testbench for the buffered UART queue pair stream block.
module buffered_uart_queue_pair_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic            ok;
		buq_pkg::byte_t  data_out;
		logic            tx_start;
		logic            tx_busy;
		buq_pkg::count_t rx_overflow_total;
		buq_pkg::count_t tx_done_total;
	} uart_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [buq_pkg::IN_DATA_W-1:0]  s_tdata;
	buq_pkg::action_t               s_tuser;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [buq_pkg::OUT_DATA_W-1:0] m_tdata;

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned mismatch_count;

	uart_result_t pending_uart_results[$];

	// Shadow copy of both queues and the transmitter status.
	buq_pkg::byte_t  rx_mem[buq_pkg::QUEUE_DEPTH];
	buq_pkg::byte_t  tx_mem[buq_pkg::QUEUE_DEPTH];
	buq_pkg::qidx_t  rx_wr, rx_rd, tx_wr, tx_rd;
	logic            tx_running;
	buq_pkg::count_t rx_drops;
	buq_pkg::count_t tx_idles;

	buffered_uart_queue_pair i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	function automatic buq_pkg::qidx_t bump_idx(buq_pkg::qidx_t i);
		return (i == buq_pkg::qidx_t'(buq_pkg::QUEUE_DEPTH - 1)) ?
			buq_pkg::qidx_t'(0) : buq_pkg::qidx_t'(i + 1'b1);
	endfunction

	function automatic uart_result_t predict_uart_event(buq_pkg::action_t act,
			buq_pkg::byte_t din);
		uart_result_t r;
		r = '0;
		case (act)
			buq_pkg::ACT_RX_BYTE: begin
				if (bump_idx(rx_wr) == rx_rd) begin
					rx_drops = rx_drops + 1'b1;
				end else begin
					rx_mem[rx_wr] = din;
					rx_wr = bump_idx(rx_wr);
					r.ok = 1'b1;
				end
			end
			buq_pkg::ACT_TX_TICK: begin
				if (tx_rd == tx_wr) begin
					tx_running = 1'b0;
					tx_idles = tx_idles + 1'b1;
				end else begin
					r.data_out = tx_mem[tx_rd];
					tx_rd = bump_idx(tx_rd);
					r.ok = 1'b1;
				end
			end
			buq_pkg::ACT_HOST_READ: begin
				if (rx_rd != rx_wr) begin
					r.data_out = rx_mem[rx_rd];
					rx_rd = bump_idx(rx_rd);
					r.ok = 1'b1;
				end
			end
			default: begin
				// A refused write to a full queue leaves the busy flag alone.
				if (bump_idx(tx_wr) != tx_rd) begin
					tx_mem[tx_wr] = din;
					tx_wr = bump_idx(tx_wr);
					r.ok = 1'b1;
					if (!tx_running) begin
						tx_running = 1'b1;
						r.tx_start = 1'b1;
					end
				end
			end
		endcase
		r.tx_busy = tx_running;
		r.rx_overflow_total = rx_drops;
		r.tx_done_total = tx_idles;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_event(buq_pkg::action_t act, buq_pkg::byte_t din);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= din;
		s_tuser  <= act;
		do begin
			@(posedge clk);
		end while (!s_tready);
		pending_uart_results.push_back(predict_uart_event(act, din));
		@(negedge clk);
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic buq_pkg::byte_t rand_byte();
		return buq_pkg::byte_t'($urandom_range(255));
	endfunction

	function automatic buq_pkg::action_t pick_action();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 35) begin
			return buq_pkg::ACT_RX_BYTE;
		end else if (roll < 50) begin
			return buq_pkg::ACT_TX_TICK;
		end else if (roll < 70) begin
			return buq_pkg::ACT_HOST_READ;
		end
		return buq_pkg::ACT_HOST_WRITE;
	endfunction

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		uart_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_uart_results.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[31:0], 32'h0);
			end else begin
				want = pending_uart_results.pop_front();
				if (m_tdata[0] !== want.ok)
					report_mismatch("ok", 32'(m_tdata[0]), 32'(want.ok));
				if (m_tdata[8:1] !== want.data_out)
					report_mismatch("data_out", 32'(m_tdata[8:1]), 32'(want.data_out));
				if (m_tdata[9] !== want.tx_start)
					report_mismatch("tx_start", 32'(m_tdata[9]), 32'(want.tx_start));
				if (m_tdata[10] !== want.tx_busy)
					report_mismatch("tx_busy", 32'(m_tdata[10]), 32'(want.tx_busy));
				if (m_tdata[42:11] !== want.rx_overflow_total)
					report_mismatch("rx_overflow_total", m_tdata[42:11],
						want.rx_overflow_total);
				if (m_tdata[74:43] !== want.tx_done_total)
					report_mismatch("tx_done_total", m_tdata[74:43], want.tx_done_total);
				if (m_tdata[buq_pkg::OUT_DATA_W-1:75] !== '0)
					report_mismatch("padding", 32'(m_tdata[buq_pkg::OUT_DATA_W-1:75]),
						32'h0);
			end
		end
	end

	// Empty-queue cases, extreme bytes, busy flag and start pulse behavior.
	task automatic test_directed();
		send_event(buq_pkg::ACT_HOST_READ, 8'h00);
		send_event(buq_pkg::ACT_TX_TICK, 8'h00);
		send_event(buq_pkg::ACT_RX_BYTE, 8'h00);
		send_event(buq_pkg::ACT_RX_BYTE, 8'hFF);
		send_event(buq_pkg::ACT_RX_BYTE, 8'hA5);
		send_event(buq_pkg::ACT_HOST_READ, 8'hFF);
		send_event(buq_pkg::ACT_HOST_READ, 8'h00);
		send_event(buq_pkg::ACT_HOST_WRITE, 8'hFF);
		send_event(buq_pkg::ACT_HOST_WRITE, 8'h00);
		send_event(buq_pkg::ACT_TX_TICK, 8'hFF);
		send_event(buq_pkg::ACT_TX_TICK, 8'h00);
		send_event(buq_pkg::ACT_TX_TICK, 8'h00);
		send_event(buq_pkg::ACT_TX_TICK, 8'hFF);
		send_event(buq_pkg::ACT_HOST_WRITE, 8'h5A);
		send_event(buq_pkg::ACT_TX_TICK, 8'hC3);
		send_event(buq_pkg::ACT_HOST_READ, 8'h00);
		send_event(buq_pkg::ACT_HOST_READ, 8'hFF);
		send_event(buq_pkg::ACT_RX_BYTE, 8'h3C);
		send_event(buq_pkg::ACT_HOST_WRITE, 8'h81);
		send_event(buq_pkg::ACT_HOST_WRITE, 8'h7E);
		stop_sending();
	endtask

	// Fills both queues past full, then drains both past empty.
	task automatic test_queue_limits();
		for (int i = 0; i < buq_pkg::QUEUE_DEPTH + 3; i++) begin
			send_event(buq_pkg::ACT_RX_BYTE, rand_byte());
			send_event(buq_pkg::ACT_HOST_WRITE, rand_byte());
		end
		for (int i = 0; i < buq_pkg::QUEUE_DEPTH + 2; i++) begin
			send_event(buq_pkg::ACT_HOST_READ, rand_byte());
			send_event(buq_pkg::ACT_TX_TICK, rand_byte());
		end
		stop_sending();
	endtask

	task automatic test_random_mix(int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			send_event(pick_action(), rand_byte());
		end
		stop_sending();
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = buq_pkg::ACT_RX_BYTE;
		mismatch_count = 0;
		rx_wr = '0;
		rx_rd = '0;
		tx_wr = '0;
		tx_rd = '0;
		tx_running = 1'b0;
		rx_drops = '0;
		tx_idles = '0;
		send_idle_pct = 29;
		recv_idle_pct = 60;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_mix(200);
		send_idle_pct = 60;
		recv_idle_pct = 29;
		test_queue_limits();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_mix(200);

		while (pending_uart_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> buffered_uart_queue_pair.f
rtl/core/buq_pkg.sv
rtl/core/buq_ram.sv
rtl/core/buq_queue.sv
rtl/core/buffered_uart_queue_pair.sv
rtl/core/buq_checker.sv
sim/buffered_uart_queue_pair_tb.sv
